@@ src/suid_pkg.sv @@
// Shared constants and types for the sorted unique identifier insert block.
// No dependencies.
`default_nettype none

package suid_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDENT_W   = 31;
    localparam int SLOT_W    = 6;
    localparam int ENTRIES_W = 7;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int S_TDATA_W = ((IDENT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + ENTRIES_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_CLEARED   = 2'd3
    } status_t;

    typedef logic [IDENT_W-1:0] ident_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ADDR_W-1:0]  addr_t;

endpackage

`default_nettype wire

@@ src/suid_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module suid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/sorted_unique_id_insert.sv @@
// Sorted unique identifier list: binary search over a registered-read RAM, then a
// descending shift that opens the slot. Depends on suid_pkg and suid_ram.
// A clear goes from the accepted beat through S_EMIT to the result beat. An insert
// alternates S_SEARCH (RAM read) and S_CMP (compare) per search step, then goes
// to S_DECIDE, S_SHIFT once per entry moved, S_INS and S_EMIT.
// One item is in work at a time; the result register frees the input side.
// Reset (aresetn low, synchronous) empties the list; RAM contents stay unset.
`default_nettype none

module sorted_unique_id_insert (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [suid_pkg::S_TDATA_W-1:0]    s_tdata,  // ident
    input  wire logic                              s_tuser,  // op
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [suid_pkg::M_TDATA_W-1:0]    m_tdata,  // slot, entries
    output logic      [suid_pkg::STATUS_W-1:0]     m_tuser   // status
);
    import suid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_DECIDE,
        S_SHIFT,
        S_INS,
        S_EMIT
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    cnt_t    lo_reg, lo_next;
    cnt_t    hi_reg, hi_next;
    cnt_t    k_reg, k_next;
    addr_t   mid_reg, mid_next;
    ident_t  id_reg, id_next;
    status_t res_status_reg, res_status_next;
    cnt_t    res_slot_reg, res_slot_next;
    cnt_t    res_entries_reg, res_entries_next;
    logic    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    status_t m_status_reg, m_status_next;

    logic             ram_we;
    addr_t            ram_waddr;
    ident_t           ram_wdata;
    addr_t            ram_raddr;
    ident_t           ram_rdata;
    logic [CNT_W:0]   mid_sum;
    cnt_t             mid;

    suid_ram #(
        .WIDTH (IDENT_W),
        .DEPTH (CAPACITY)
    ) u_ids (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        k_next           = k_reg;
        mid_next         = mid_reg;
        id_next          = id_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_entries_next = res_entries_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_status_next    = m_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = ADDR_W'(k_reg);
        ram_wdata        = ram_rdata;
        ram_raddr        = ADDR_W'(mid);

        // drop the result beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    id_next = s_tdata[IDENT_W-1:0];
                    lo_next = '0;
                    hi_next = count_reg;
                    if (!s_tuser) begin
                        count_next       = '0;
                        res_status_next  = ST_CLEARED;
                        res_slot_next    = '0;
                        res_entries_next = '0;
                        state_next       = S_EMIT;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    ram_raddr  = ADDR_W'(mid);
                    mid_next   = ADDR_W'(mid);
                    state_next = S_CMP;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_CMP: begin
                if (ram_rdata == id_reg) begin
                    res_status_next  = ST_DUPLICATE;
                    res_slot_next    = CNT_W'(mid_reg);
                    res_entries_next = count_reg;
                    state_next       = S_EMIT;
                end else begin
                    if (ram_rdata < id_reg) begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end else begin
                        hi_next = CNT_W'(mid_reg);
                    end
                    state_next = S_SEARCH;
                end
            end
            S_DECIDE: begin
                if (count_reg == CNT_W'(CAPACITY)) begin
                    res_status_next  = ST_FULL;
                    res_slot_next    = '0;
                    res_entries_next = count_reg;
                    state_next       = S_EMIT;
                end else if (count_reg > lo_reg) begin
                    // start the shift at the top entry
                    ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                    k_next     = count_reg;
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_INS;
                end
            end
            S_SHIFT: begin
                // move entry k-1 up to k while reading k-2
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(k_reg);
                ram_wdata = ram_rdata;
                k_next    = k_reg - CNT_W'(1);
                if ((k_reg - CNT_W'(1)) > lo_reg) begin
                    ram_raddr = ADDR_W'(k_reg - CNT_W'(2));
                end else begin
                    state_next = S_INS;
                end
            end
            S_INS: begin
                ram_we           = 1'b1;
                ram_waddr        = ADDR_W'(lo_reg);
                ram_wdata        = id_reg;
                count_next       = count_reg + CNT_W'(1);
                res_status_next  = ST_INSERTED;
                res_slot_next    = lo_reg;
                res_entries_next = count_reg + CNT_W'(1);
                state_next       = S_EMIT;
            end
            S_EMIT: begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = M_TDATA_W'({ENTRIES_W'(res_entries_reg),
                                                SLOT_W'(res_slot_reg)});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        k_reg           <= k_next;
        mid_reg         <= mid_next;
        id_reg          <= id_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_entries_reg <= res_entries_next;
        m_data_reg      <= m_data_next;
        m_status_reg    <= m_status_next;
    end

endmodule

`default_nettype wire

@@ sim/sorted_unique_id_insert_tb.sv @@
// Self-checking bench for sorted_unique_id_insert: an in-bench sorted-list predictor
// checks every result beat against its input beat. Depends on suid_pkg and the block's RTL.
module sorted_unique_id_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import suid_pkg::*;

    localparam int     ITEM_TARGET     = 950;
    localparam int     CYCLE_LIMIT     = 1_000_000;
    localparam int     HOLD_OFF_CYCLES = 600;
    localparam int     MAX_PRINTED     = 100;
    localparam bit     OP_CLEAR        = 1'b0;
    localparam bit     OP_INSERT       = 1'b1;
    localparam ident_t IDENT_MAX       = '1;

    typedef struct packed {
        status_t               status;
        logic [SLOT_W-1:0]     slot;
        logic [ENTRIES_W-1:0]  entries;
    } outcome_t;

    class id_list_scoreboard;
        ident_t      held_ids[CAPACITY];
        int unsigned held_count;
        outcome_t    outcome_q[$];
        int          errors;
        int          checked;

        function new();
            held_count = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        // Apply one accepted input beat to the list and queue the outcome.
        function void note_item(bit op, ident_t ident);
            outcome_t    o;
            int unsigned pos;
            int unsigned k;
            pos = 0;
            if (op == OP_CLEAR) begin
                held_count = 0;
                o.status   = ST_CLEARED;
                o.slot     = '0;
                o.entries  = '0;
            end else begin
                while (pos < held_count && held_ids[pos] < ident)
                    pos++;
                if (pos < held_count && held_ids[pos] == ident) begin
                    o.status  = ST_DUPLICATE;
                    o.slot    = SLOT_W'(pos);
                    o.entries = ENTRIES_W'(held_count);
                end else if (held_count >= CAPACITY) begin
                    o.status  = ST_FULL;
                    o.slot    = '0;
                    o.entries = ENTRIES_W'(held_count);
                end else begin
                    for (k = held_count; k > pos; k--)
                        held_ids[k] = held_ids[k-1];
                    held_ids[pos] = ident;
                    held_count++;
                    o.status  = ST_INSERTED;
                    o.slot    = SLOT_W'(pos);
                    o.entries = ENTRIES_W'(held_count);
                end
            end
            outcome_q.push_back(o);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR at %0t ns: %s", $time, what);
        endtask

        task check_result(status_t status, logic [SLOT_W-1:0] slot,
                          logic [ENTRIES_W-1:0] entries);
            outcome_t e;
            checked++;
            if (outcome_q.size() == 0) begin
                report($sformatf("result beat with nothing pending: status=%0d slot=%0d entries=%0d",
                                 status, slot, entries));
            end else begin
                e = outcome_q.pop_front();
                if (status !== e.status)
                    report($sformatf("status got %0d want %0d", status, e.status));
                if (slot !== e.slot)
                    report($sformatf("slot got %0d want %0d", slot, e.slot));
                if (entries !== e.entries)
                    report($sformatf("entries got %0d want %0d", entries, e.entries));
            end
        endtask

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // ident, zero pad
    logic                   s_tuser  = 1'b0;  // op
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;  // slot, entries, zero pad
    logic [STATUS_W-1:0]    m_tuser;  // status

    id_list_scoreboard sb;
    ident_t            sent_ids[$];
    int                items_sent  = 0;
    int                cycle_count = 0;
    bit                burst       = 1'b0;

    sorted_unique_id_insert u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[IDENT_W-1:0]);
            if (m_tvalid && m_tready)
                sb.check_result(status_t'(m_tuser), m_tdata[SLOT_W-1:0],
                                m_tdata[SLOT_W +: ENTRIES_W]);
        end
    end

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function ident_t any_ident();
        return ident_t'($urandom);
    endfunction

    // Mostly a zero pool takes the full range, else 0..pool; some repeat old or edge idents.
    function ident_t next_ident(int pool);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8 && sent_ids.size() > 0)
            return sent_ids[$urandom_range(0, sent_ids.size() - 1)];
        if (r < 11)
            return ($urandom_range(0, 1) == 1) ? IDENT_MAX : ident_t'(0);
        if (pool > 0)
            return ident_t'($urandom_range(0, pool));
        return any_ident();
    endfunction

    task send_item(bit op, ident_t ident);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - IDENT_W){1'b0}}, ident};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == OP_CLEAR)
            sent_ids.delete();
        else
            sent_ids.push_back(ident);
    endtask

    // Hold the input side until every pending result beat is back.
    task drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin : sink
        int  hi;
        int  lo;
        bit  held;
        held = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            hi = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            m_tready <= 1'b1;
            repeat (hi) @(posedge aclk);
            if (!held && sb.checked >= 150) begin
                // Long back-pressure: the block fills and stalls its input.
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                lo = pick_gap();
                if (lo > 0) begin
                    m_tready <= 1'b0;
                    repeat (lo) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int kind;
        int len;
        int pool;
        int i;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_INSERT, 31'd5);
        send_item(OP_INSERT, IDENT_MAX);
        send_item(OP_INSERT, 31'd0);
        send_item(OP_INSERT, 31'd5);
        send_item(OP_INSERT, IDENT_MAX);
        send_item(OP_INSERT, 31'd0);
        send_item(OP_INSERT, 31'h5555_5555);
        send_item(OP_INSERT, 31'h2AAA_AAAA);
        send_item(OP_INSERT, 31'h4000_0000);
        send_item(OP_INSERT, 31'd1);
        send_item(OP_INSERT, IDENT_MAX - 1);
        send_item(OP_INSERT, 31'h2AAA_AAAA);
        send_item(OP_CLEAR, IDENT_MAX);
        send_item(OP_CLEAR, 31'd0);
        send_item(OP_INSERT, IDENT_MAX);
        send_item(OP_INSERT, 31'd0);
        send_item(OP_INSERT, IDENT_MAX);
        send_item(OP_CLEAR, 31'h5555_5555);
        drain();

        while (items_sent < ITEM_TARGET) begin
            kind  = $urandom_range(0, 9);
            burst = ($urandom_range(0, 3) == 0);
            if (kind == 9) begin
                // noise: random clears and inserts on whatever the list holds
                len = $urandom_range(1, 15);
                for (i = 0; i < len; i++)
                    send_item($urandom_range(0, 1), any_ident());
            end else begin
                send_item(OP_CLEAR, any_ident());
                if (kind <= 3) begin
                    pool = $urandom_range(8, 127);
                    len  = $urandom_range(20, 120);
                end else if (kind <= 6) begin
                    pool = 0;
                    len  = $urandom_range(1, 40);
                end else begin
                    // up to CAPACITY + 26 inserts, mostly fresh idents, aimed at running past capacity
                    pool = 0;
                    len  = $urandom_range(CAPACITY, CAPACITY + 26);
                end
                for (i = 0; i < len; i++)
                    send_item(OP_INSERT, next_ident(pool));
            end
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        drain();
        repeat (100) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
src/suid_pkg.sv
src/suid_ram.sv
src/sorted_unique_id_insert.sv
sim/sorted_unique_id_insert_tb.sv
